/* sv/u8rd_pkg.sv */
// ---------------------------------------------------------------------------
// u8rd_pkg
// Shared types, constants and helpers of the UTF-8 replacing decoder.
// ---------------------------------------------------------------------------
`default_nettype none

package u8rd_pkg;

    localparam logic [20:0] REPL_CP   = 21'h00FFFD;
    localparam logic [20:0] CP_MAX    = 21'h10FFFF;
    localparam logic [20:0] SURR_LO   = 21'h00D800;
    localparam logic [20:0] SURR_HI   = 21'h00DFFF;
    localparam logic [20:0] MIN_3B    = 21'h000800;
    localparam logic [20:0] MIN_4B    = 21'h010000;

    localparam logic [7:0]  ASCII_MAX = 8'h7F;
    localparam logic [7:0]  LEAD2_MIN = 8'hC2;
    localparam logic [7:0]  LEAD2_MAX = 8'hDF;
    localparam logic [7:0]  LEAD3_MAX = 8'hEF;
    localparam logic [7:0]  LEAD4_MAX = 8'hF7;

    localparam logic [16:0] BYTE_SAT  = 17'h1FFFF;
    localparam logic [15:0] UNIT_SAT  = 16'hFFFF;

    localparam logic [14:0] MAX_CHARS_RST = 15'h7FFF;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_BYTES = 2'd1,
        ST_UNITS = 2'd2
    } status_t;

    // Results of one byte: nrep replacements, then an optional decoded point.
    typedef struct packed {
        logic [2:0]  nrep;
        logic        tail_vld;
        logic [20:0] tail_cp;
        logic        fin;
        status_t     status;
        logic [15:0] base_units;
    } burst_t;

    function automatic logic [1:0] units_of(input logic [20:0] cp);
        return (cp >= MIN_4B) ? 2'd2 : 2'd1;
    endfunction

    function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [2:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {14'd0, b};
        return s[16] ? UNIT_SAT : s[15:0];
    endfunction

endpackage

`default_nettype wire

/* sv/u8rd_decode.sv */
// ---------------------------------------------------------------------------
// u8rd_decode
// Sequence state, running counts and per-byte burst description.
// ---------------------------------------------------------------------------
`default_nettype none

module u8rd_decode (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            accept,
    input  wire logic [7:0]      byte_value,
    input  wire logic            final_byte,
    input  wire logic [14:0]     max_chars,
    output u8rd_pkg::burst_t     burst,
    output logic                 burst_vld
);

    logic [20:0] pp_reg,     pp_next;
    logic [1:0]  needed_reg, needed_next;
    logic [1:0]  held_reg,   held_next;
    logic [15:0] unit_reg,   unit_next;
    logic [16:0] byte_reg,   byte_next;

    logic [20:0] pp_shift;
    logic [20:0] cp_done;
    logic        cont;
    logic        bad;
    logic [2:0]  len;
    logic [2:0]  nrep;
    logic        tail_vld;
    logic [20:0] tail_cp;
    logic [2:0]  add_units;
    logic [15:0] unit_new;
    logic [16:0] byte_new;
    logic [16:0] byte_limit;
    u8rd_pkg::status_t status;

    always_comb begin
        pp_shift    = {pp_reg[14:0], byte_value[5:0]};
        cont        = (needed_reg != 2'd0) && (byte_value[7:6] == 2'b10);
        pp_next     = pp_reg;
        needed_next = needed_reg;
        held_next   = held_reg;
        nrep        = 3'd0;
        tail_vld    = 1'b0;
        tail_cp     = pp_shift;
        cp_done     = pp_shift;
        len         = {1'b0, held_reg} + 3'd1;
        bad         = 1'b0;

        if (cont) begin
            if (needed_reg == 2'd1) begin
                if (len == 3'd3 && (cp_done < u8rd_pkg::MIN_3B ||
                    (cp_done >= u8rd_pkg::SURR_LO && cp_done <= u8rd_pkg::SURR_HI))) begin
                    bad = 1'b1;
                end
                if (len == 3'd4 && (cp_done < u8rd_pkg::MIN_4B ||
                    cp_done > u8rd_pkg::CP_MAX)) begin
                    bad = 1'b1;
                end
                if (bad) begin
                    nrep = len;
                end else begin
                    tail_vld = 1'b1;
                end
                pp_next     = '0;
                needed_next = 2'd0;
                held_next   = 2'd0;
            end else begin
                pp_next     = pp_shift;
                needed_next = needed_reg - 2'd1;
                held_next   = held_reg + 2'd1;
            end
        end else begin
            // flush the interrupted sequence, then decode this byte fresh
            if (needed_reg != 2'd0) begin
                nrep = {1'b0, held_reg};
            end
            pp_next     = '0;
            needed_next = 2'd0;
            held_next   = 2'd0;
            tail_cp     = {13'd0, byte_value};
            if (byte_value <= u8rd_pkg::ASCII_MAX) begin
                tail_vld = 1'b1;
            end else if (byte_value >= u8rd_pkg::LEAD2_MIN &&
                         byte_value <= u8rd_pkg::LEAD2_MAX) begin
                pp_next     = {16'd0, byte_value[4:0]};
                needed_next = 2'd1;
                held_next   = 2'd1;
            end else if (byte_value > u8rd_pkg::LEAD2_MAX &&
                         byte_value <= u8rd_pkg::LEAD3_MAX) begin
                pp_next     = {17'd0, byte_value[3:0]};
                needed_next = 2'd2;
                held_next   = 2'd1;
            end else if (byte_value > u8rd_pkg::LEAD3_MAX &&
                         byte_value <= u8rd_pkg::LEAD4_MAX) begin
                pp_next     = {18'd0, byte_value[2:0]};
                needed_next = 2'd3;
                held_next   = 2'd1;
            end else begin
                nrep = nrep + 3'd1;
            end
        end

        // truncated at string end: replace every held byte
        if (final_byte && needed_next != 2'd0) begin
            nrep = nrep + {1'b0, held_next};
        end

        add_units  = nrep + (tail_vld ? {1'b0, u8rd_pkg::units_of(tail_cp)} : 3'd0);
        unit_new   = u8rd_pkg::sat_add(unit_reg, add_units);
        byte_new   = (byte_reg == u8rd_pkg::BYTE_SAT) ? byte_reg : byte_reg + 17'd1;
        byte_limit = {1'b0, max_chars, 1'b0} + {2'd0, max_chars};

        if (byte_new > byte_limit) begin
            status = u8rd_pkg::ST_BYTES;
        end else if (unit_new > {1'b0, max_chars}) begin
            status = u8rd_pkg::ST_UNITS;
        end else begin
            status = u8rd_pkg::ST_OK;
        end

        unit_next = unit_new;
        byte_next = byte_new;
        if (final_byte) begin
            pp_next     = '0;
            needed_next = 2'd0;
            held_next   = 2'd0;
            unit_next   = '0;
            byte_next   = '0;
        end

        burst.nrep       = nrep;
        burst.tail_vld   = tail_vld;
        burst.tail_cp    = tail_cp;
        burst.fin        = final_byte;
        burst.status     = status;
        burst.base_units = unit_reg;
        burst_vld        = (nrep != 3'd0) || tail_vld;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pp_reg     <= '0;
            needed_reg <= 2'd0;
            held_reg   <= 2'd0;
            unit_reg   <= '0;
            byte_reg   <= '0;
        end else if (accept) begin
            pp_reg     <= pp_next;
            needed_reg <= needed_next;
            held_reg   <= held_next;
            unit_reg   <= unit_next;
            byte_reg   <= byte_next;
        end
    end

endmodule

`default_nettype wire

/* sv/u8rd_emit.sv */
// ---------------------------------------------------------------------------
// u8rd_emit
// Result register: plays out the burst of one byte, one result per request.
// ---------------------------------------------------------------------------
`default_nettype none

module u8rd_emit (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            load,
    input  wire u8rd_pkg::burst_t burst,
    input  wire logic            out_ready,
    output logic                 in_ready,
    output logic                 out_valid,
    output logic [20:0]          code_point,
    output logic [1:0]           utf16_units,
    output logic                 was_replaced,
    output logic                 string_end,
    output logic [15:0]          unit_total,
    output logic [1:0]           status
);

    logic        vld_reg;
    logic [2:0]  rem_reg;
    logic        tail_vld_reg;
    logic [20:0] tail_cp_reg;
    logic        fin_reg;
    u8rd_pkg::status_t status_reg;
    logic [15:0] total_reg;

    logic        last;
    logic        fire;
    logic [1:0]  first_units;
    logic [1:0]  next_units;

    always_comb begin
        last         = (rem_reg == 3'd0) || (rem_reg == 3'd1 && !tail_vld_reg);
        fire         = vld_reg && out_ready;
        in_ready     = !vld_reg || (out_ready && last);
        out_valid    = vld_reg;
        was_replaced = (rem_reg != 3'd0);
        code_point   = was_replaced ? u8rd_pkg::REPL_CP : tail_cp_reg;
        utf16_units  = was_replaced ? 2'd1 : u8rd_pkg::units_of(tail_cp_reg);
        string_end   = fin_reg && last;
        status       = string_end ? status_reg : u8rd_pkg::ST_OK;
        unit_total   = total_reg;
        first_units  = (burst.nrep != 3'd0) ? 2'd1 : u8rd_pkg::units_of(burst.tail_cp);
        next_units   = (rem_reg > 3'd1) ? 2'd1 : u8rd_pkg::units_of(tail_cp_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
            rem_reg <= 3'd0;
        end else if (load) begin
            vld_reg <= 1'b1;
            rem_reg <= burst.nrep;
        end else if (fire) begin
            if (last) begin
                vld_reg <= 1'b0;
            end else if (rem_reg != 3'd0) begin
                rem_reg <= rem_reg - 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            tail_vld_reg <= burst.tail_vld;
            tail_cp_reg  <= burst.tail_cp;
            fin_reg      <= burst.fin;
            status_reg   <= burst.status;
            total_reg    <= u8rd_pkg::sat_add(burst.base_units, {1'b0, first_units});
        end else if (fire && !last) begin
            total_reg    <= u8rd_pkg::sat_add(total_reg, {1'b0, next_units});
        end
    end

endmodule

`default_nettype wire

/* sv/utf8_replacing_decoder_counter.sv */
// ---------------------------------------------------------------------------
// utf8_replacing_decoder_counter
// The first result of a byte is offered the cycle after the byte is accepted.
// Throughput: one byte per cycle while m_tready is high and each byte gives at
// most one result; a byte with more results holds the register until the last.
// Reset (synchronous, aresetn low) clears sequence state and counts and sets
// max_chars to 32767.
// ---------------------------------------------------------------------------
`default_nettype none

module utf8_replacing_decoder_counter (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [14:0] cfg_wdata,     // max_chars
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,       // [7:0] byte_value
    input  wire logic        s_tlast,       // final_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,       // [20:0] code_point, [22:21] utf16_units,
                                            // [38:23] unit_total, [40:39] status
    output logic             m_tuser,       // was_replaced
    output logic             m_tlast        // string_end
);

    logic [14:0]       max_chars_reg;
    logic              s_fire;
    logic              burst_vld;
    u8rd_pkg::burst_t  burst;
    logic [20:0]       code_point;
    logic [1:0]        utf16_units;
    logic [15:0]       unit_total;
    logic [1:0]        status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_chars_reg <= u8rd_pkg::MAX_CHARS_RST;
        end else if (cfg_we) begin
            max_chars_reg <= cfg_wdata;
        end
    end

    assign s_fire = s_tvalid && s_tready;

    u8rd_decode u_decode (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (s_fire),
        .byte_value (s_tdata),
        .final_byte (s_tlast),
        .max_chars  (max_chars_reg),
        .burst      (burst),
        .burst_vld  (burst_vld)
    );

    u8rd_emit u_emit (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (s_fire && burst_vld),
        .burst        (burst),
        .out_ready    (m_tready),
        .in_ready     (s_tready),
        .out_valid    (m_tvalid),
        .code_point   (code_point),
        .utf16_units  (utf16_units),
        .was_replaced (m_tuser),
        .string_end   (m_tlast),
        .unit_total   (unit_total),
        .status       (status)
    );

    assign m_tdata = {7'd0, status, unit_total, utf16_units, code_point};

    // status is only reported on the last result of a string
    a_status_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> status == u8rd_pkg::ST_OK)
        else $error("status set on a result that does not end the string");

    a_repl_point: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> code_point == u8rd_pkg::REPL_CP && utf16_units == 2'd1)
        else $error("replacement result carries a wrong code point");

    a_units_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |->
            (utf16_units == 2'd2) == (code_point >= u8rd_pkg::MIN_4B))
        else $error("utf16_units does not match code_point");

    // a result that waits on m_tready blocks new bytes, also the last of its burst
    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted while the result register is stalled");

endmodule

`default_nettype wire

/* tb/utf8_replacing_decoder_counter_test.sv */
// ---------------------------------------------------------------------------
// utf8_replacing_decoder_counter_test
// Streams UTF-8 strings into the decoder and checks every decoded code point,
// replacement flag, running UTF-16 unit total and end-of-string status against
// a cycle-free predictor. Covers directed edge cases, random well-formed and
// malformed strings under several max_chars settings, and random idling on both
// sides.
// ---------------------------------------------------------------------------
module utf8_replacing_decoder_counter_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PER_BYTE = 4;

    typedef struct {
        logic [7:0] data;
        logic       fin;
    } byte_req_t;

    typedef struct {
        logic [20:0]       code;
        logic [1:0]        units;
        logic              repl;
        logic              ends;
        logic [15:0]       total;
        u8rd_pkg::status_t stat;
    } point_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [14:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    utf8_replacing_decoder_counter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    byte_req_t  byte_reqs[$];
    point_t     decoded_due[$];
    point_t     step_out[$];
    logic [7:0] str_buf[$];
    byte_req_t  req;
    int         send_wait = 0;
    int         recv_wait = 0;
    int         err_count = 0;
    bit         no_gaps   = 1'b0;

    // Predictor state
    logic [14:0] lim_chars = u8rd_pkg::MAX_CHARS_RST;
    logic [20:0] acc_cp    = '0;
    logic [1:0]  need_cnt  = '0;
    logic [1:0]  held_cnt  = '0;
    logic [15:0] units_run = '0;
    logic [16:0] bytes_run = '0;

    task automatic put_point(input logic [20:0] cp, input logic repl);
        point_t p;
        if (step_out.size() < MAX_PER_BYTE) begin
            p.units = (cp >= u8rd_pkg::MIN_4B) ? 2'd2 : 2'd1;
            if (int'(units_run) + int'(p.units) > int'(u8rd_pkg::UNIT_SAT))
                units_run = u8rd_pkg::UNIT_SAT;
            else
                units_run = units_run + p.units;
            p.code  = cp;
            p.repl  = repl;
            p.ends  = 1'b0;
            p.total = units_run;
            p.stat  = u8rd_pkg::ST_OK;
            step_out.insert(step_out.size(), p);
        end
    endtask

    task automatic put_repl(input int n);
        for (int i = 0; i < n; i++)
            put_point(u8rd_pkg::REPL_CP, 1'b1);
    endtask

    task automatic decode_lead(input logic [7:0] b);
        if (b <= u8rd_pkg::ASCII_MAX) begin
            put_point({13'd0, b}, 1'b0);
        end else if (b >= u8rd_pkg::LEAD2_MIN && b <= u8rd_pkg::LEAD2_MAX) begin
            acc_cp   = {16'd0, b[4:0]};
            need_cnt = 2'd1;
            held_cnt = 2'd1;
        end else if (b > u8rd_pkg::LEAD2_MAX && b <= u8rd_pkg::LEAD3_MAX) begin
            acc_cp   = {17'd0, b[3:0]};
            need_cnt = 2'd2;
            held_cnt = 2'd1;
        end else if (b > u8rd_pkg::LEAD3_MAX && b <= u8rd_pkg::LEAD4_MAX) begin
            acc_cp   = {18'd0, b[2:0]};
            need_cnt = 2'd3;
            held_cnt = 2'd1;
        end else begin
            put_point(u8rd_pkg::REPL_CP, 1'b1);
        end
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic fin);
        int                len;
        logic              bad;
        u8rd_pkg::status_t st;
        step_out.delete();
        if (bytes_run != u8rd_pkg::BYTE_SAT)
            bytes_run = bytes_run + 17'd1;
        if (need_cnt != 2'd0 && b[7:6] == 2'b10) begin
            acc_cp   = {acc_cp[14:0], b[5:0]};
            need_cnt = need_cnt - 2'd1;
            if (need_cnt == 2'd0) begin
                len = int'(held_cnt) + 1;
                bad = (len == 3 && (acc_cp < u8rd_pkg::MIN_3B ||
                                    (acc_cp >= u8rd_pkg::SURR_LO &&
                                     acc_cp <= u8rd_pkg::SURR_HI))) ||
                      (len == 4 && (acc_cp < u8rd_pkg::MIN_4B ||
                                    acc_cp > u8rd_pkg::CP_MAX));
                if (bad)
                    put_repl(len);
                else
                    put_point(acc_cp, 1'b0);
                held_cnt = '0;
                acc_cp   = '0;
            end else begin
                held_cnt = held_cnt + 2'd1;
            end
        end else begin
            // flush the interrupted sequence, then take the byte as a new lead
            if (need_cnt != 2'd0) begin
                put_repl(int'(held_cnt));
                held_cnt = '0;
                need_cnt = '0;
                acc_cp   = '0;
            end
            decode_lead(b);
        end
        if (fin) begin
            st = u8rd_pkg::ST_OK;
            if (need_cnt != 2'd0)
                put_repl(int'(held_cnt));
            if (int'(bytes_run) > 3 * int'(lim_chars))
                st = u8rd_pkg::ST_BYTES;
            else if (int'(units_run) > int'(lim_chars))
                st = u8rd_pkg::ST_UNITS;
            if (step_out.size() > 0) begin
                step_out[step_out.size() - 1].ends = 1'b1;
                step_out[step_out.size() - 1].stat = st;
            end
            acc_cp    = '0;
            need_cnt  = '0;
            held_cnt  = '0;
            units_run = '0;
            bytes_run = '0;
        end
        foreach (step_out[i])
            decoded_due.insert(decoded_due.size(), step_out[i]);
    endtask

    // Request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_wait = 0;
        end else begin
            if (s_tvalid && s_tready)
                decode_byte(s_tdata, s_tlast);
            if (!s_tvalid || s_tready) begin
                if (send_wait > 0) begin
                    send_wait--;
                    s_tvalid <= 1'b0;
                end else if (byte_reqs.size() != 0) begin
                    req = byte_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= req.data;
                    s_tlast  <= req.fin;
                    send_wait = no_gaps ? 0 : $urandom_range(0, 3);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_point();
        point_t want;
        logic   bad;
        if (decoded_due.size() == 0) begin
            err_count++;
            if (err_count <= 10)
                $display("%0t: unexpected result cp %h repl %b end %b total %0d status %0d",
                         $realtime, m_tdata[20:0], m_tuser, m_tlast, m_tdata[38:23],
                         m_tdata[40:39]);
        end else begin
            want = decoded_due.pop_front();
            bad  = m_tdata[20:0] !== want.code || m_tdata[22:21] !== want.units ||
                   m_tuser !== want.repl || m_tlast !== want.ends ||
                   m_tdata[38:23] !== want.total || m_tdata[40:39] !== want.stat ||
                   m_tdata[47:41] !== 7'd0;
            if (bad) begin
                err_count++;
                if (err_count <= 10) begin
                    $display("%0t: mismatch exp cp %h units %0d repl %b end %b total %0d st %0d",
                             $realtime, want.code, want.units, want.repl, want.ends,
                             want.total, want.stat);
                    $display("%0t:          got cp %h units %0d repl %b end %b total %0d st %0d pad %h",
                             $realtime, m_tdata[20:0], m_tdata[22:21], m_tuser, m_tlast,
                             m_tdata[38:23], m_tdata[40:39], m_tdata[47:41]);
                end
            end
        end
    endtask

    // Result monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            recv_wait = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                check_point();
                recv_wait = no_gaps ? 0 : $urandom_range(0, 3);
            end
            if (recv_wait > 0) begin
                recv_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic put_byte(input logic [7:0] b);
        str_buf.insert(str_buf.size(), b);
    endtask

    task automatic send_string();
        byte_req_t r;
        foreach (str_buf[i]) begin
            r.data = str_buf[i];
            r.fin  = (i == str_buf.size() - 1);
            byte_reqs.insert(byte_reqs.size(), r);
        end
        str_buf.delete();
    endtask

    // Encode cp in a len-byte form whether or not that form is legal
    task automatic push_raw(input logic [20:0] cp, input int len);
        case (len)
            1: put_byte({1'b0, cp[6:0]});
            2: begin
                put_byte({3'b110, cp[10:6]});
                put_byte({2'b10, cp[5:0]});
            end
            3: begin
                put_byte({4'b1110, cp[15:12]});
                put_byte({2'b10, cp[11:6]});
                put_byte({2'b10, cp[5:0]});
            end
            default: begin
                put_byte({5'b11110, cp[20:18]});
                put_byte({2'b10, cp[17:12]});
                put_byte({2'b10, cp[11:6]});
                put_byte({2'b10, cp[5:0]});
            end
        endcase
    endtask

    function automatic logic [20:0] valid_point(input int len);
        logic [20:0] cp;
        case (len)
            1: cp = 21'($urandom_range(0, 'h7F));
            2: cp = 21'($urandom_range('h80, 'h7FF));
            3: begin
                cp = 21'($urandom_range('h800, 'hFFFF));
                if (cp >= u8rd_pkg::SURR_LO && cp <= u8rd_pkg::SURR_HI)
                    cp = cp ^ 21'h1000;
            end
            default: cp = 21'($urandom_range('h10000, 'h10FFFF));
        endcase
        return cp;
    endfunction

    task automatic add_token();
        int kind;
        int len;
        int pick;
        kind = $urandom_range(0, 19);
        len  = $urandom_range(1, 4);
        if (kind < 13) begin
            push_raw(valid_point(len), len);
        end else if (kind == 13) begin
            // lone continuation or a byte that can never lead
            pick = $urandom_range(0, 9);
            if ($urandom_range(0, 1))
                put_byte(8'($urandom_range('h80, 'hBF)));
            else if (pick < 2)
                put_byte(8'(8'hC0 + pick));
            else
                put_byte(8'(8'hF8 + (pick - 2)));
        end else if (kind <= 15) begin
            // drop the tail of a legal sequence
            len = $urandom_range(2, 4);
            push_raw(valid_point(len), len);
            repeat ($urandom_range(1, len - 1))
                void'(str_buf.pop_back());
        end else if (kind == 16) begin
            // overlong form
            if ($urandom_range(0, 1))
                push_raw(21'($urandom_range(0, 'h7FF)), 3);
            else
                push_raw(21'($urandom_range(0, 'hFFFF)), 4);
        end else if (kind == 17) begin
            push_raw(21'($urandom_range('hD800, 'hDFFF)), 3);
        end else if (kind == 18) begin
            push_raw(21'($urandom_range('h110000, 'h1FFFFF)), 4);
        end else begin
            put_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        while (byte_reqs.size() != 0 || s_tvalid || decoded_due.size() != 0)
            @(negedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_limit(input logic [14:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        lim_chars = value;
    endtask

    task automatic run_strings(input int n_bytes);
        int sent;
        sent = 0;
        @(negedge aclk);
        while (sent < n_bytes) begin
            repeat ($urandom_range(1, 6))
                add_token();
            sent += str_buf.size();
            send_string();
        end
        wait_idle();
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // byte and code point extremes
        str_buf = '{8'h00};                      send_string();
        str_buf = '{8'hFF};                      send_string();
        str_buf = '{8'hF4, 8'h8F, 8'hBF, 8'hBF}; send_string();
        // three held bytes cut off by a bad lead: four replacements
        str_buf = '{8'hF0, 8'h90, 8'h80, 8'hC1}; send_string();
        // overlong, surrogate, above the code space
        str_buf = '{8'hE0, 8'h80, 8'h80};        send_string();
        str_buf = '{8'hED, 8'hA0, 8'h80};        send_string();
        str_buf = '{8'hF4, 8'h90, 8'h80, 8'h80}; send_string();
        // lone continuation, then a sequence truncated by the end of string
        str_buf = '{8'h80, 8'hE2, 8'h82};        send_string();
        // two-byte sequence interrupted by ASCII, then a dangling lead
        str_buf = '{8'hC2, 8'h41, 8'hDF};        send_string();
        wait_idle();

        set_limit(15'd0);
        run_strings(30);
        set_limit(15'd5);
        run_strings(130);
        no_gaps = 1'b1;
        set_limit(15'd1);
        run_strings(50);
        no_gaps = 1'b0;
        set_limit(15'($urandom_range(2, 40)));
        run_strings(80);
        set_limit(15'h7FFF);
        run_strings(100);

        if (decoded_due.size() != 0)
            err_count++;
        if (err_count == 0)
            $display("utf8_replacing_decoder_counter_test: PASS");
        else
            $display("utf8_replacing_decoder_counter_test: FAIL");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("utf8_replacing_decoder_counter_test: FAIL");
        $finish;
    end

endmodule
